// ===== hw/rtl/ata_pio_host_sequencer_macros.svh =====
// assertion macros shared by the ata pio host sequencer rtl
`ifndef ATA_PIO_HOST_SEQUENCER_MACROS_SVH
`define ATA_PIO_HOST_SEQUENCER_MACROS_SVH

// same-cycle implication
`define AHPS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ahps assertion failed");

// next-cycle implication
`define AHPS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ahps assertion failed");

`endif

// ===== hw/rtl/ahps_pkg.sv =====
// types, constants and result helpers of the ata pio host sequencer
`default_nettype none

package ahps_pkg;

	localparam int unsigned SECTOR_WORDS = 256;
	localparam int unsigned IDENT_WORDS  = 256;
	localparam int unsigned DELAY_READS  = 4;
	localparam int unsigned WIDX_W       = $clog2(IDENT_WORDS + 1);
	localparam int unsigned DELAY_W      = 3;
	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned STEP_W       = 3;

	localparam logic [15:0] ST_BSY = 16'h0080;
	localparam logic [15:0] ST_DF  = 16'h0020;
	localparam logic [15:0] ST_DRQ = 16'h0008;
	localparam logic [15:0] ST_ERR = 16'h0001;

	localparam logic [2:0] REG_DATA    = 3'd0;
	localparam logic [2:0] REG_FEATURE = 3'd1;
	localparam logic [2:0] REG_COUNT   = 3'd2;
	localparam logic [2:0] REG_LBA_LO  = 3'd3;
	localparam logic [2:0] REG_LBA_MID = 3'd4;
	localparam logic [2:0] REG_LBA_HI  = 3'd5;
	localparam logic [2:0] REG_DRIVE   = 3'd6;
	localparam logic [2:0] REG_CMD     = 3'd7;
	localparam logic [2:0] REG_STATUS  = 3'd7;

	localparam logic [7:0] CMD_READ         = 8'h20;
	localparam logic [7:0] CMD_WRITE        = 8'h30;
	localparam logic [7:0] CMD_IDENTIFY     = 8'hEC;
	localparam logic [7:0] CMD_PKT_IDENTIFY = 8'hA1;
	localparam logic [7:0] CMD_FLUSH        = 8'hE7;

	localparam logic [7:0] DRV_LBA_MASTER = 8'hE0;
	localparam logic [7:0] DRV_LBA_SLAVE  = 8'hF0;
	localparam logic [7:0] DRV_CHS_MASTER = 8'hA0;
	localparam logic [7:0] DRV_CHS_SLAVE  = 8'hB0;
	localparam logic [7:0] LBA_TOP_MASK   = 8'h0F;

	typedef enum logic [2:0] {
		OP_START_READ   = 3'd0,
		OP_START_WRITE  = 3'd1,
		OP_IDENTIFY     = 3'd2,
		OP_PKT_IDENTIFY = 3'd3,
		OP_BUS_RESP     = 3'd4,
		OP_WRITE_WORD   = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_READ      = 2'd0,
		KIND_WRITE     = 2'd1,
		KIND_IDENT     = 2'd2,
		KIND_PKT_IDENT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OC_OK       = 2'd0,
		OC_DEV_ERR  = 2'd1,
		OC_NO_DRIVE = 2'd2
	} outcome_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SEL_DELAY,
		PH_POLL,
		PH_RD_DATA,
		PH_SECT_DELAY,
		PH_WR_WAIT,
		PH_ID_BSY,
		PH_ID_DRQ,
		PH_ID_ERR,
		PH_ID_DATA
	} phase_t;

	typedef enum logic [3:0] {
		ACT_SELECT,
		ACT_STATUS,
		ACT_SETUP_ID,
		ACT_SETUP_PKT,
		ACT_SETUP_RW,
		ACT_FINISH,
		ACT_DATA_READ,
		ACT_WORD_READ,
		ACT_WORD_STATUS,
		ACT_ID_LAST,
		ACT_WR_WORD,
		ACT_WR_SECT_END
	} act_t;

	typedef struct packed {
		act_t        act;
		logic [15:0] data;
		logic [7:0]  count;
		logic [23:0] addr;
		outcome_t    outcome;
	} act_desc_t;

	typedef struct packed {
		logic      valid;
		act_desc_t desc;
	} push_t;

	typedef struct packed {
		logic        req_valid;
		logic        req_write;
		logic [2:0]  req_offset;
		logic        req_wide;
		logic [15:0] req_data;
		logic        word_valid;
		logic [15:0] word_out;
		logic        done_res;
		logic [1:0]  outcome;
		logic        last;
	} result_t;

	function automatic result_t res_wr8(input logic [2:0] off, input logic [7:0] val);
		result_t r;
		r = '0;
		r.req_valid  = 1'b1;
		r.req_write  = 1'b1;
		r.req_offset = off;
		r.req_data   = {8'h00, val};
		return r;
	endfunction

	function automatic result_t res_wr16(input logic [2:0] off, input logic [15:0] val);
		result_t r;
		r = '0;
		r.req_valid  = 1'b1;
		r.req_write  = 1'b1;
		r.req_offset = off;
		r.req_wide   = 1'b1;
		r.req_data   = val;
		return r;
	endfunction

	function automatic result_t res_status();
		result_t r;
		r = '0;
		r.req_valid  = 1'b1;
		r.req_offset = REG_STATUS;
		return r;
	endfunction

	function automatic result_t res_data_read();
		result_t r;
		r = '0;
		r.req_valid  = 1'b1;
		r.req_offset = REG_DATA;
		r.req_wide   = 1'b1;
		return r;
	endfunction

	function automatic result_t res_word(input logic [15:0] w, input logic done);
		result_t r;
		r = '0;
		r.word_valid = 1'b1;
		r.word_out   = w;
		r.done_res   = done;
		return r;
	endfunction

	function automatic result_t res_done(input outcome_t oc);
		result_t r;
		r = '0;
		r.done_res = 1'b1;
		r.outcome  = oc;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ahps_if.sv =====
// item and result channel interfaces of the ata pio host sequencer
`default_nettype none

interface ahps_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic        drive_slave;
	logic [27:0] block_address;
	logic [7:0]  sector_total;
	logic [15:0] data_in;

	modport source (output valid, opcode, drive_slave, block_address, sector_total, data_in,
		input ready);
	modport sink (input valid, opcode, drive_slave, block_address, sector_total, data_in,
		output ready);
endinterface

interface ahps_result_if;
	logic        valid;
	logic        ready;
	logic        req_valid;
	logic        req_write;
	logic [2:0]  req_offset;
	logic        req_wide;
	logic [15:0] req_data;
	logic        word_valid;
	logic [15:0] word_out;
	logic        done_res;
	logic [1:0]  outcome;
	logic        last;

	modport source (output valid, req_valid, req_write, req_offset, req_wide, req_data,
		word_valid, word_out, done_res, outcome, last, input ready);
	modport sink (input valid, req_valid, req_write, req_offset, req_wide, req_data,
		word_valid, word_out, done_res, outcome, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ata_pio_host_sequencer.sv =====
// top level of the ata pio host sequencer: front end, action queue, back end
// an item is taken every cycle while the four-entry action queue has room
// its action, if any, passes the queue and then the output register as results;
// results leave one per cycle unless result.ready stalls them; a queued action pops
// with its last result; reset idles phase machine, empties queue and output register
`default_nettype none

module ata_pio_host_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ahps_item_if.sink        item,
	ahps_result_if.source    result
);

	ahps_pkg::push_t      push;
	ahps_pkg::act_desc_t  head;
	logic                 q_valid;
	logic                 q_full;
	logic                 pop;

	ahps_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.q_full (q_full),
		.push   (push)
	);

	ahps_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.q_valid (q_valid),
		.head    (head),
		.full    (q_full)
	);

	ahps_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ahps_front.sv =====
// front end: takes items, runs the command phase machine, queues actions
`default_nettype none
`include "ata_pio_host_sequencer_macros.svh"

module ahps_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	ahps_item_if.sink           item,
	input  wire logic           q_full,
	output ahps_pkg::push_t     push
);

	ahps_pkg::phase_t                  phase_q, phase_d;
	ahps_pkg::kind_t                   kind_q, kind_d;
	logic [23:0]                       addr_q, addr_d;
	logic [7:0]                        sectors_q, sectors_d;
	logic [ahps_pkg::WIDX_W-1:0]       word_idx_q, word_idx_d;
	logic [ahps_pkg::DELAY_W-1:0]      delay_q, delay_d;

	logic                              take;
	logic [15:0]                       v;
	logic                              st_go;
	logic                              st_fail;
	logic                              st_drq;
	logic                              st_err;
	logic                              st_bsy;
	logic [ahps_pkg::DELAY_W-1:0]      delay_dec;
	logic [ahps_pkg::WIDX_W-1:0]       widx_inc;
	logic                              sect_end;
	logic                              id_end;
	logic                              ident_kind;
	logic [7:0]                        sel_lba;
	logic [7:0]                        sel_chs;

	assign item.ready = !q_full;
	assign take       = item.valid && item.ready;
	assign v          = item.data_in;

	assign st_bsy     = (v & ahps_pkg::ST_BSY) != 16'h0000;
	assign st_drq     = (v & ahps_pkg::ST_DRQ) != 16'h0000;
	assign st_err     = (v & ahps_pkg::ST_ERR) != 16'h0000;
	assign st_fail    = st_err || ((v & ahps_pkg::ST_DF) != 16'h0000);
	assign st_go      = !st_bsy || st_drq;
	assign delay_dec  = delay_q - 1'b1;
	assign widx_inc   = word_idx_q + 1'b1;
	assign sect_end   = widx_inc >= ahps_pkg::WIDX_W'(ahps_pkg::SECTOR_WORDS);
	assign id_end     = widx_inc >= ahps_pkg::WIDX_W'(ahps_pkg::IDENT_WORDS);
	assign ident_kind = (kind_q == ahps_pkg::KIND_IDENT) || (kind_q == ahps_pkg::KIND_PKT_IDENT);
	assign sel_lba    = (item.drive_slave ? ahps_pkg::DRV_LBA_SLAVE : ahps_pkg::DRV_LBA_MASTER)
		| ({4'h0, item.block_address[27:24]} & ahps_pkg::LBA_TOP_MASK);
	assign sel_chs    = item.drive_slave ? ahps_pkg::DRV_CHS_SLAVE : ahps_pkg::DRV_CHS_MASTER;

	// next state
	always_comb begin
		phase_d    = phase_q;
		kind_d     = kind_q;
		addr_d     = addr_q;
		sectors_d  = sectors_q;
		word_idx_d = word_idx_q;
		delay_d    = delay_q;
		if (take) begin
			case (item.opcode)
				ahps_pkg::OP_START_READ, ahps_pkg::OP_START_WRITE,
				ahps_pkg::OP_IDENTIFY, ahps_pkg::OP_PKT_IDENTIFY: begin
					if (phase_q == ahps_pkg::PH_IDLE) begin
						kind_d     = ahps_pkg::kind_t'(item.opcode[1:0]);
						word_idx_d = '0;
						phase_d    = ahps_pkg::PH_SEL_DELAY;
						delay_d    = ahps_pkg::DELAY_W'(ahps_pkg::DELAY_READS);
						if (!item.opcode[1]) begin
							addr_d    = item.block_address[23:0];
							sectors_d = item.sector_total;
						end
					end
				end
				ahps_pkg::OP_BUS_RESP: begin
					case (phase_q)
						ahps_pkg::PH_SEL_DELAY, ahps_pkg::PH_SECT_DELAY: begin
							delay_d = delay_dec;
							if (delay_dec == '0) begin
								if (phase_q == ahps_pkg::PH_SEL_DELAY && ident_kind) begin
									phase_d = ahps_pkg::PH_ID_BSY;
								end else begin
									phase_d = ahps_pkg::PH_POLL;
								end
							end
						end
						ahps_pkg::PH_POLL: begin
							if (st_go) begin
								if (sectors_q == 8'h00) begin
									phase_d = ahps_pkg::PH_IDLE;
								end else begin
									word_idx_d = '0;
									phase_d = (kind_q == ahps_pkg::KIND_READ) ?
										ahps_pkg::PH_RD_DATA : ahps_pkg::PH_WR_WAIT;
								end
							end else if (st_fail) begin
								phase_d = ahps_pkg::PH_IDLE;
							end
						end
						ahps_pkg::PH_RD_DATA: begin
							if (sect_end) begin
								word_idx_d = '0;
								sectors_d  = sectors_q - 1'b1;
								phase_d    = ahps_pkg::PH_SECT_DELAY;
								delay_d    = ahps_pkg::DELAY_W'(ahps_pkg::DELAY_READS);
							end else begin
								word_idx_d = widx_inc;
							end
						end
						ahps_pkg::PH_ID_BSY: begin
							if (v == 16'h0000) begin
								phase_d = ahps_pkg::PH_IDLE;
							end else if (!st_bsy) begin
								phase_d = ahps_pkg::PH_ID_DRQ;
							end
						end
						ahps_pkg::PH_ID_DRQ: begin
							if (st_drq) begin
								phase_d = ahps_pkg::PH_ID_ERR;
							end else if (st_fail) begin
								phase_d = ahps_pkg::PH_IDLE;
							end
						end
						ahps_pkg::PH_ID_ERR: begin
							if (st_err) begin
								phase_d = ahps_pkg::PH_IDLE;
							end else begin
								word_idx_d = '0;
								phase_d    = ahps_pkg::PH_ID_DATA;
							end
						end
						ahps_pkg::PH_ID_DATA: begin
							if (id_end) begin
								word_idx_d = '0;
								phase_d    = ahps_pkg::PH_IDLE;
							end else begin
								word_idx_d = widx_inc;
							end
						end
						default: begin
						end
					endcase
				end
				ahps_pkg::OP_WRITE_WORD: begin
					if (phase_q == ahps_pkg::PH_WR_WAIT) begin
						if (sect_end) begin
							word_idx_d = '0;
							sectors_d  = sectors_q - 1'b1;
							phase_d    = ahps_pkg::PH_SECT_DELAY;
							delay_d    = ahps_pkg::DELAY_W'(ahps_pkg::DELAY_READS);
						end else begin
							word_idx_d = widx_inc;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// queued action
	always_comb begin
		push = '0;
		push.desc.data = v;
		if (take) begin
			case (item.opcode)
				ahps_pkg::OP_START_READ, ahps_pkg::OP_START_WRITE: begin
					push.valid     = phase_q == ahps_pkg::PH_IDLE;
					push.desc.act  = ahps_pkg::ACT_SELECT;
					push.desc.data = {8'h00, sel_lba};
				end
				ahps_pkg::OP_IDENTIFY, ahps_pkg::OP_PKT_IDENTIFY: begin
					push.valid     = phase_q == ahps_pkg::PH_IDLE;
					push.desc.act  = ahps_pkg::ACT_SELECT;
					push.desc.data = {8'h00, sel_chs};
				end
				ahps_pkg::OP_BUS_RESP: begin
					push.valid = 1'b1;
					case (phase_q)
						ahps_pkg::PH_SEL_DELAY, ahps_pkg::PH_SECT_DELAY: begin
							push.desc.act = ahps_pkg::ACT_STATUS;
							if (delay_dec == '0 && phase_q == ahps_pkg::PH_SEL_DELAY) begin
								case (kind_q)
									ahps_pkg::KIND_IDENT: begin
										push.desc.act = ahps_pkg::ACT_SETUP_ID;
									end
									ahps_pkg::KIND_PKT_IDENT: begin
										push.desc.act = ahps_pkg::ACT_SETUP_PKT;
									end
									default: begin
										push.desc.act   = ahps_pkg::ACT_SETUP_RW;
										push.desc.count = sectors_q;
										push.desc.addr  = addr_q;
										push.desc.data  = {8'h00,
											(kind_q == ahps_pkg::KIND_READ) ?
											ahps_pkg::CMD_READ : ahps_pkg::CMD_WRITE};
									end
								endcase
							end
						end
						ahps_pkg::PH_POLL: begin
							if (st_go) begin
								if (sectors_q == 8'h00) begin
									push.desc.act     = ahps_pkg::ACT_FINISH;
									push.desc.outcome = ahps_pkg::OC_OK;
								end else if (kind_q == ahps_pkg::KIND_READ) begin
									push.desc.act = ahps_pkg::ACT_DATA_READ;
								end else begin
									push.valid = 1'b0;
								end
							end else if (st_fail) begin
								push.desc.act     = ahps_pkg::ACT_FINISH;
								push.desc.outcome = ahps_pkg::OC_DEV_ERR;
							end else begin
								push.desc.act = ahps_pkg::ACT_STATUS;
							end
						end
						ahps_pkg::PH_RD_DATA: begin
							push.desc.act = sect_end ?
								ahps_pkg::ACT_WORD_STATUS : ahps_pkg::ACT_WORD_READ;
						end
						ahps_pkg::PH_ID_BSY: begin
							if (v == 16'h0000) begin
								push.desc.act     = ahps_pkg::ACT_FINISH;
								push.desc.outcome = ahps_pkg::OC_NO_DRIVE;
							end else begin
								push.desc.act = ahps_pkg::ACT_STATUS;
							end
						end
						ahps_pkg::PH_ID_DRQ: begin
							if (!st_drq && st_fail) begin
								push.desc.act     = ahps_pkg::ACT_FINISH;
								push.desc.outcome = ahps_pkg::OC_DEV_ERR;
							end else begin
								push.desc.act = ahps_pkg::ACT_STATUS;
							end
						end
						ahps_pkg::PH_ID_ERR: begin
							if (st_err) begin
								push.desc.act     = ahps_pkg::ACT_FINISH;
								push.desc.outcome = ahps_pkg::OC_DEV_ERR;
							end else begin
								push.desc.act = ahps_pkg::ACT_DATA_READ;
							end
						end
						ahps_pkg::PH_ID_DATA: begin
							push.desc.act = id_end ?
								ahps_pkg::ACT_ID_LAST : ahps_pkg::ACT_WORD_READ;
						end
						default: begin
							push.valid = 1'b0;
						end
					endcase
				end
				ahps_pkg::OP_WRITE_WORD: begin
					push.valid    = phase_q == ahps_pkg::PH_WR_WAIT;
					push.desc.act = sect_end ?
						ahps_pkg::ACT_WR_SECT_END : ahps_pkg::ACT_WR_WORD;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ahps_pkg::PH_IDLE;
			kind_q     <= ahps_pkg::KIND_READ;
			addr_q     <= '0;
			sectors_q  <= '0;
			word_idx_q <= '0;
			delay_q    <= '0;
		end else begin
			phase_q    <= phase_d;
			kind_q     <= kind_d;
			addr_q     <= addr_d;
			sectors_q  <= sectors_d;
			word_idx_q <= word_idx_d;
			delay_q    <= delay_d;
		end
	end

	`AHPS_ASSERT_NOW(a_widx_range, clk, arst_n, 1'b1,
		word_idx_q < ahps_pkg::WIDX_W'(ahps_pkg::IDENT_WORDS))
	`AHPS_ASSERT_NOW(a_wr_wait_has_sector, clk, arst_n,
		phase_q == ahps_pkg::PH_WR_WAIT, sectors_q != 8'h00)

endmodule

`default_nettype wire

// ===== hw/rtl/ahps_queue.sv =====
// short action queue between front and back ends
`default_nettype none
`include "ata_pio_host_sequencer_macros.svh"

module ahps_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ahps_pkg::push_t     push,
	input  wire logic                pop,
	output logic                     q_valid,
	output ahps_pkg::act_desc_t      head,
	output logic                     full
);

	ahps_pkg::act_desc_t                slots_q [ahps_pkg::QUEUE_DEPTH];
	logic [ahps_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [ahps_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [ahps_pkg::QCNT_W-1:0]        count_q;

	assign q_valid = count_q != '0;
	assign full    = count_q == ahps_pkg::QCNT_W'(ahps_pkg::QUEUE_DEPTH);
	assign head    = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slots_q[wr_ptr_q] <= push.desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`AHPS_ASSERT_NOW(a_no_push_when_full, clk, arst_n, push.valid, !full)
	`AHPS_ASSERT_NOW(a_no_pop_when_empty, clk, arst_n, pop, q_valid)

endmodule

`default_nettype wire

// ===== hw/rtl/ahps_back.sv =====
// back end: expands queued actions into results behind an output register
`default_nettype none
`include "ata_pio_host_sequencer_macros.svh"

module ahps_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire ahps_pkg::act_desc_t   head,
	output logic                       pop,
	ahps_result_if.source              result
);

	logic [ahps_pkg::STEP_W-1:0]  step_q;
	logic                         out_valid_q;
	ahps_pkg::result_t            res_q;
	ahps_pkg::result_t            res;
	logic                         is_last;
	logic                         advance;

	always_comb begin
		res     = '0;
		is_last = 1'b1;
		case (head.act)
			ahps_pkg::ACT_SELECT: begin
				res = (step_q == '0) ? ahps_pkg::res_wr8(ahps_pkg::REG_DRIVE, head.data[7:0])
					: ahps_pkg::res_status();
				is_last = step_q == 3'd1;
			end
			ahps_pkg::ACT_STATUS: begin
				res = ahps_pkg::res_status();
			end
			ahps_pkg::ACT_SETUP_ID: begin
				if (step_q < 3'd4) begin
					res = ahps_pkg::res_wr8(3'(ahps_pkg::REG_COUNT + step_q), 8'h00);
				end else if (step_q == 3'd4) begin
					res = ahps_pkg::res_wr8(ahps_pkg::REG_CMD, ahps_pkg::CMD_IDENTIFY);
				end else begin
					res = ahps_pkg::res_status();
				end
				is_last = step_q == 3'd5;
			end
			ahps_pkg::ACT_SETUP_PKT: begin
				res = (step_q == '0) ?
					ahps_pkg::res_wr8(ahps_pkg::REG_CMD, ahps_pkg::CMD_PKT_IDENTIFY)
					: ahps_pkg::res_status();
				is_last = step_q == 3'd1;
			end
			ahps_pkg::ACT_SETUP_RW: begin
				case (step_q)
					3'd0:    res = ahps_pkg::res_wr8(ahps_pkg::REG_FEATURE, 8'h00);
					3'd1:    res = ahps_pkg::res_wr8(ahps_pkg::REG_COUNT, head.count);
					3'd2:    res = ahps_pkg::res_wr8(ahps_pkg::REG_LBA_LO, head.addr[7:0]);
					3'd3:    res = ahps_pkg::res_wr8(ahps_pkg::REG_LBA_MID, head.addr[15:8]);
					3'd4:    res = ahps_pkg::res_wr8(ahps_pkg::REG_LBA_HI, head.addr[23:16]);
					3'd5:    res = ahps_pkg::res_wr8(ahps_pkg::REG_CMD, head.data[7:0]);
					default: res = ahps_pkg::res_status();
				endcase
				is_last = step_q == 3'd6;
			end
			ahps_pkg::ACT_FINISH: begin
				res = ahps_pkg::res_done(head.outcome);
			end
			ahps_pkg::ACT_DATA_READ: begin
				res = ahps_pkg::res_data_read();
			end
			ahps_pkg::ACT_WORD_READ: begin
				res = (step_q == '0) ? ahps_pkg::res_word(head.data, 1'b0)
					: ahps_pkg::res_data_read();
				is_last = step_q == 3'd1;
			end
			ahps_pkg::ACT_WORD_STATUS: begin
				res = (step_q == '0) ? ahps_pkg::res_word(head.data, 1'b0)
					: ahps_pkg::res_status();
				is_last = step_q == 3'd1;
			end
			ahps_pkg::ACT_ID_LAST: begin
				res = ahps_pkg::res_word(head.data, 1'b1);
			end
			ahps_pkg::ACT_WR_WORD: begin
				res = ahps_pkg::res_wr16(ahps_pkg::REG_DATA, head.data);
			end
			ahps_pkg::ACT_WR_SECT_END: begin
				case (step_q)
					3'd0:    res = ahps_pkg::res_wr16(ahps_pkg::REG_DATA, head.data);
					3'd1:    res = ahps_pkg::res_wr16(ahps_pkg::REG_CMD,
						{8'h00, ahps_pkg::CMD_FLUSH});
					default: res = ahps_pkg::res_status();
				endcase
				is_last = step_q == 3'd2;
			end
			default: begin
			end
		endcase
		res.last = is_last;
	end

	assign advance = q_valid && (!out_valid_q || result.ready);
	assign pop     = advance && is_last;

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q      <= is_last ? '0 : step_q + 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.req_valid  = res_q.req_valid;
	assign result.req_write  = res_q.req_write;
	assign result.req_offset = res_q.req_offset;
	assign result.req_wide   = res_q.req_wide;
	assign result.req_data   = res_q.req_data;
	assign result.word_valid = res_q.word_valid;
	assign result.word_out   = res_q.word_out;
	assign result.done_res   = res_q.done_res;
	assign result.outcome    = res_q.outcome;
	assign result.last       = res_q.last;

	`AHPS_ASSERT_NEXT(a_step_clears_on_pop, clk, arst_n, pop, step_q == '0)
	`AHPS_ASSERT_NOW(a_step_only_multi, clk, arst_n, q_valid && step_q != '0,
		head.act == ahps_pkg::ACT_SELECT || head.act == ahps_pkg::ACT_SETUP_ID ||
		head.act == ahps_pkg::ACT_SETUP_PKT || head.act == ahps_pkg::ACT_SETUP_RW ||
		head.act == ahps_pkg::ACT_WORD_READ || head.act == ahps_pkg::ACT_WORD_STATUS ||
		head.act == ahps_pkg::ACT_WR_SECT_END)

endmodule

`default_nettype wire
